// File: sv/psd_pkg.sv
// Shared types and constants for the point sort and dedupe block.
`default_nettype none
package psd_pkg;

  // Width of every coordinate field on the ports
  localparam int FIELD_W = 32;

  // Input beat: one point
  typedef struct packed {
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic                      last_point;
  } in_beat_t;

  // Output beat: one distinct point
  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic                      out_last;
    logic                      dropped;
  } out_beat_t;

  // Controller state
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert broadcast key in order
    logic pop;  // shift chain toward cell 0
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/psd_stream_if.sv
// Valid/ready stream channel with a typed payload.
`default_nettype none
interface psd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/psd_cell.sv
// One sorting cell: holds a key, inserts in order, shifts on pop.
`default_nettype none
module psd_cell
  import psd_pkg::*;
#(
  parameter int KEY_W = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic             left_valid,
  input  wire logic             left_lt,
  input  wire logic [KEY_W-1:0] right_key,
  input  wire logic             right_valid,
  output logic      [KEY_W-1:0] key,
  output logic                  valid,
  output logic                  lt
);

  // New key belongs at or before this slot
  assign lt = !valid || (in_key < key);

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end else if (ctrl.ins && lt) begin
      valid <= left_lt ? left_valid : 1'b1;
    end
  end

  // Key: right neighbor shifts in on pop; on insert the left neighbor shifts in, or the new key lands here
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      key <= right_key;
    end else if (ctrl.ins && lt) begin
      key <= left_lt ? left_key : in_key;
    end
  end

endmodule
`default_nettype wire

// File: sv/point_sort_dedupe.sv
// Input: a point beat is accepted every cycle while loading. After the last point the block
// drains: the first pop fills the hold stage, and each held point is registered at the output
// once a differing point is popped or the chain empties. Each pop shifts the cell chain one
// step toward cell 0, only while the output register is free; duplicates give no beat.
// Reset: synchronous; clears cell valid bits, the controller state and overflow flag at once.
`default_nettype none
module point_sort_dedupe
  import psd_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  psd_stream_if.sink   point,
  psd_stream_if.source result
);

  localparam int KEY_W = 2 * COORD_BITS;
  localparam logic [COORD_BITS-1:0] SIGN_MASK = {1'b1, {(COORD_BITS-1){1'b0}}};

  state_t     st, st_next;
  cell_ctrl_t ctrl;

  logic [KEY_W-1:0]      ckey [MAX_POINTS];
  logic [MAX_POINTS-1:0] cvalid;
  logic [MAX_POINTS-1:0] clt;

  logic [KEY_W-1:0] in_key;
  logic [KEY_W-1:0] hold_key;
  logic             hold_valid;
  logic             overflow;
  logic             res_valid;
  out_beat_t        res_data;

  logic accept, full, out_free, dup, emit_mid, emit_end, done;
  logic signed [COORD_BITS-1:0] hx, hy;

  // Order key: sign bit flipped so an unsigned compare gives signed order
  assign in_key = {point.data.x_coord[COORD_BITS-1:0] ^ SIGN_MASK,
                   point.data.y_coord[COORD_BITS-1:0] ^ SIGN_MASK};

  assign full     = cvalid[MAX_POINTS-1];
  assign accept   = point.valid && point.ready;
  assign out_free = !res_valid || result.ready;
  assign dup      = hold_valid && (ckey[0] == hold_key);

  // Cell chain
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic             lv, ll, rv;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lv = 1'b1;
      assign ll = 1'b0;
    end else begin : g_mid
      assign lk = ckey[i-1];
      assign lv = cvalid[i-1];
      assign ll = clt[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_last
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rk = ckey[i+1];
      assign rv = cvalid[i+1];
    end
    psd_cell #(.KEY_W(KEY_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_key     (in_key),
      .left_key   (lk),
      .left_valid (lv),
      .left_lt    (ll),
      .right_key  (rk),
      .right_valid(rv),
      .key        (ckey[i]),
      .valid      (cvalid[i]),
      .lt         (clt[i])
    );
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      ST_LOAD:  if (accept && point.data.last_point) st_next = ST_DRAIN;
      ST_DRAIN: if (done) st_next = ST_LOAD;
      default:  st_next = ST_LOAD;
    endcase
  end

  // Control outputs
  always_comb begin
    point.ready = 1'b0;
    ctrl        = '0;
    emit_mid    = 1'b0;
    emit_end    = 1'b0;
    done        = 1'b0;
    case (st)
      ST_LOAD: begin
        point.ready = 1'b1;
        ctrl.ins    = point.valid && !full;
      end
      ST_DRAIN: begin
        ctrl.pop = cvalid[0] && out_free;
        emit_mid = ctrl.pop && hold_valid && !dup;
        emit_end = !cvalid[0] && hold_valid && out_free;
        done     = !cvalid[0] && (!hold_valid || out_free);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_LOAD;
    end else begin
      st <= st_next;
    end
  end

  // Overflow flag: set on a point that finds the chain full
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow <= 1'b0;
    end else if (done) begin
      overflow <= 1'b0;
    end else if (accept && full) begin
      overflow <= 1'b1;
    end
  end

  // Hold stage: last distinct key popped, sent once the next one differs or the chain empties
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (ctrl.pop && !dup) begin
      hold_valid <= 1'b1;
    end else if (emit_end) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop && !dup) begin
      hold_key <= ckey[0];
    end
  end

  // Output register
  assign hx = hold_key[KEY_W-1 -: COORD_BITS] ^ SIGN_MASK;
  assign hy = hold_key[COORD_BITS-1:0] ^ SIGN_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= emit_mid || emit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (emit_mid || emit_end)) begin
      res_data.out_x    <= FIELD_W'(hx);
      res_data.out_y    <= FIELD_W'(hy);
      res_data.out_last <= emit_end;
      res_data.dropped  <= overflow;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

  // Chain head stays ordered
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    cvalid[1] |-> (cvalid[0] && (ckey[0] <= ckey[1])))
    else $error("cell chain out of order");

  // No insertion while draining
  a_no_ins_drain: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DRAIN) |-> !ctrl.ins)
    else $error("insert during drain");

  // A drain always starts with at least one stored point
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DRAIN && $past(st) == ST_LOAD) |-> cvalid[0])
    else $error("drain started on empty chain");

endmodule
`default_nettype wire

// File: tb/point_sort_dedupe_tb.sv
// Testbench for point_sort_dedupe: random point sets, sorted and deduplicated predictions.
`default_nettype none
module point_sort_dedupe_tb;
  import psd_pkg::*;

  localparam int          MAX_PTS     = 64;
  localparam int          CRD_BITS    = 32;
  localparam int          HOLD_CYCLES = 200;
  localparam int          STALL_LIMIT = 5000;
  localparam int          PHASE_BEATS = 50;
  localparam bit [31:0]   SIGN_FLIP   = 32'h8000_0000;

  // Predicts the sorted, deduplicated run of each point set and checks results
  class sorted_point_board;
    int unsigned capacity;
    bit [63:0]   held_keys[$];
    bit          spilled;
    out_beat_t   pending[$];
    int unsigned errors;

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    task report(string msg);
      if (errors < 50) begin
        $display("MISMATCH @%0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    // Note one accepted point beat; a last point releases the whole run
    task take_point(in_beat_t b);
      bit [31:0] xs;
      bit [31:0] ys;
      bit [63:0] k;
      out_beat_t r;
      out_beat_t run[$];
      xs = b.x_coord;
      ys = b.y_coord;
      if (held_keys.size() < capacity) begin
        held_keys.insert(held_keys.size(), {xs ^ SIGN_FLIP, ys ^ SIGN_FLIP});
      end else begin
        spilled = 1'b1;
      end
      if (!b.last_point) return;
      // unsigned order of flipped keys equals signed (x, y) order
      held_keys.sort();
      for (int i = 0; i < held_keys.size(); i++) begin
        k = held_keys[i];
        if (i > 0 && k == held_keys[i-1]) continue;
        r.out_x    = k[63:32] ^ SIGN_FLIP;
        r.out_y    = k[31:0] ^ SIGN_FLIP;
        r.out_last = 1'b0;
        r.dropped  = spilled;
        run.insert(run.size(), r);
      end
      if (run.size() > 0) run[run.size()-1].out_last = 1'b1;
      pending = {pending, run};
      held_keys.delete();
      spilled = 1'b0;
    endtask

    // Compare one accepted result beat against the oldest prediction
    task check_point(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result x=%0d y=%0d last=%0b dropped=%0b",
                         got.out_x, got.out_y, got.out_last, got.dropped));
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.out_x !== want.out_x)
        report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
      if (got.out_last !== want.out_last)
        report($sformatf("out_last got %0b want %0b (x=%0d y=%0d)",
                         got.out_last, want.out_last, want.out_x, want.out_y));
      if (got.dropped !== want.dropped)
        report($sformatf("dropped got %0b want %0b (x=%0d y=%0d)",
                         got.dropped, want.dropped, want.out_x, want.out_y));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  psd_stream_if #(.T(in_beat_t))  point_if ();
  psd_stream_if #(.T(out_beat_t)) result_if ();

  point_sort_dedupe #(
    .MAX_POINTS(MAX_PTS),
    .COORD_BITS(CRD_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .point(point_if),
    .result(result_if)
  );

  sorted_point_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_left;
  int beats_sent;
  int quiet_cycles;

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) board.check_point(result_if.data);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (point_if.valid && point_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("point_sort_dedupe verification failed");
        $finish;
      end
    end
  end

  // Offer one point, idling first at the current rate; returns once accepted
  task send_pt(int x, int y, bit last);
    in_beat_t b;
    b.x_coord    = x;
    b.y_coord    = y;
    b.last_point = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      point_if.valid <= 1'b0;
      @(posedge clk);
    end
    point_if.valid <= 1'b1;
    point_if.data  <= b;
    @(posedge clk);
    while (!point_if.ready) @(posedge clk);
    board.take_point(b);
    beats_sent++;
  endtask

  // Pooled values collide often, giving duplicates and shared x
  function int pick_coord(bit pooled);
    if (!pooled) return $urandom;
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  task send_set(int n, bit pooled);
    for (int i = 0; i < n; i++) send_pt(pick_coord(pooled), pick_coord(pooled), i == n - 1);
  endtask

  // Stop offering and wait until every predicted result has come back
  task wait_drained();
    point_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  localparam int MIN_C = 32'h8000_0000;
  localparam int MAX_C = 32'h7FFF_FFFF;

  initial begin
    int phase_start;
    int n;
    board          = new(MAX_PTS);
    rst            = 1'b1;
    point_if.valid = 1'b0;
    point_if.data  = '0;
    result_if.ready = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    beats_sent     = 0;
    quiet_cycles   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a lone point, extremes with duplicates, one point repeated, reversed x
    send_pt(MAX_C, MAX_C, 1'b1);
    send_pt(0, 0, 1'b0);
    send_pt(MIN_C, MIN_C, 1'b0);
    send_pt(MAX_C, MAX_C, 1'b0);
    send_pt(-1, -1, 1'b0);
    send_pt(MIN_C, MAX_C, 1'b0);
    send_pt(MAX_C, MIN_C, 1'b0);
    send_pt(0, 0, 1'b0);
    send_pt(MIN_C, MIN_C, 1'b0);
    send_pt(-1, 0, 1'b0);
    send_pt(-1, -1, 1'b1);
    for (int i = 0; i < 4; i++) send_pt(32'h5555_AAAA, 32'hAAAA_5555, i == 3);
    for (int i = 0; i < 5; i++) send_pt(40 - 10 * i, i, i == 4);
    wait_drained();

    // Random phases with varying idle rates on both sides
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      phase_start = beats_sent;
      if (phase == 0) begin
        // long output hold-off: a full store, then an overflowing set backs up the input
        hold_req = 1;
        send_set(MAX_PTS, 1'b0);
        send_set(MAX_PTS + 2, 1'b1);
        wait_drained();
      end
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(0, 9) == 0) n = $urandom_range(MAX_PTS - 1, MAX_PTS + 6);
        else n = $urandom_range(1, 12);
        send_set(n, $urandom_range(0, 1));
      end
      wait_drained();
    end

    // allow stray beats past the last prediction to show up
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("point_sort_dedupe verification clean");
    end else begin
      $display("point_sort_dedupe verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
